>>> rtl/fau_pkg.sv
`timescale 1ns / 1ps

package fau_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_GCD,
      BK_DIV,
      BK_MUL,
      BK_SUM,
      BK_OUT
   } back_state_type;

   typedef enum logic [2:0] {
      MUL_LCM,
      MUL_T1,
      MUL_T2,
      MUL_PN,
      MUL_PD,
      MUL_QN,
      MUL_QD
   } mul_sel_type;

endpackage

>>> rtl/fau_front.sv
`timescale 1ns / 1ps

module fau_front #(
   parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic signed [OPERAND_WIDTH-1:0] in_x,
   input  logic        [OPERAND_WIDTH-2:0] in_y,
   input  logic signed [OPERAND_WIDTH-1:0] in_a,
   input  logic        [OPERAND_WIDTH-2:0] in_b,
   output logic                            q_valid,
   input  logic                            q_ready,
   output logic signed [OPERAND_WIDTH-1:0] q_x,
   output logic        [OPERAND_WIDTH-2:0] q_y,
   output logic signed [OPERAND_WIDTH-1:0] q_a,
   output logic        [OPERAND_WIDTH-2:0] q_b,
   output logic                            q_y_zero,
   output logic                            q_b_zero
);

   localparam int W  = OPERAND_WIDTH;
   localparam int EW = 4 * W;

   logic [EW-1:0] entry_ff [2];
   logic [1:0]    count_ff;
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic          push;
   logic          pop;
   logic [EW-1:0] head;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign head       = entry_ff[rd_ptr_ff];

   assign q_x      = head[W-1:0];
   assign q_y      = head[2*W-2:W];
   assign q_a      = head[3*W-2:2*W-1];
   assign q_b      = head[4*W-3:3*W-1];
   assign q_y_zero = head[4*W-2];
   assign q_b_zero = head[4*W-1];

   // classify: zero denominators flagged on the way in
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {(in_b == '0), (in_y == '0), in_b, in_a, in_y, in_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

>>> rtl/fau_back.sv
`timescale 1ns / 1ps

module fau_back #(
   parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  logic signed [OPERAND_WIDTH-1:0]   q_x,
   input  logic        [OPERAND_WIDTH-2:0]   q_y,
   input  logic signed [OPERAND_WIDTH-1:0]   q_a,
   input  logic        [OPERAND_WIDTH-2:0]   q_b,
   input  logic                              q_y_zero,
   input  logic                              q_b_zero,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic        [OPERAND_WIDTH-2:0]   den_gcd,
   output logic        [2*OPERAND_WIDTH-3:0] common_den,
   output logic signed [2*OPERAND_WIDTH-1:0] sum_num,
   output logic signed [2*OPERAND_WIDTH-1:0] diff_num,
   output logic signed [2*OPERAND_WIDTH-1:0] prod_num,
   output logic        [2*OPERAND_WIDTH-3:0] prod_den,
   output logic signed [2*OPERAND_WIDTH-2:0] quot_num,
   output logic signed [2*OPERAND_WIDTH-2:0] quot_den
);

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = W - 1;
   localparam int KW = $clog2(DW);

   fau_pkg::back_state_type state_ff;
   fau_pkg::back_state_type state_in;
   fau_pkg::mul_sel_type    mul_ff;

   logic signed [W-1:0]   x_ff;
   logic signed [W-1:0]   a_ff;
   logic        [DW-1:0]  y_ff;
   logic        [DW-1:0]  b_ff;
   logic                  yz_ff;
   logic                  bz_ff;
   logic        [DW-1:0]  u_ff;
   logic        [DW-1:0]  v_ff;
   logic        [KW-1:0]  k_ff;
   logic        [DW-1:0]  g_ff;
   logic        [DW-1:0]  rem1_ff;
   logic        [DW-1:0]  rem2_ff;
   logic        [DW-1:0]  q1_ff;
   logic        [DW-1:0]  q2_ff;
   logic        [KW-1:0]  dcnt_ff;
   logic        [2*W-3:0] lcm_ff;
   logic signed [2*W-1:0] t1_ff;
   logic signed [2*W-1:0] t2_ff;
   logic signed [2*W-1:0] sum_ff;
   logic signed [2*W-1:0] diff_ff;
   logic signed [2*W-1:0] pn_ff;
   logic        [2*W-3:0] pd_ff;
   logic signed [2*W-2:0] qn_ff;
   logic signed [2*W-2:0] qd_ff;

   logic                  gcd_done;
   logic        [DW:0]    trial1;
   logic        [DW:0]    trial2;
   logic signed [W:0]     op_l;
   logic signed [W:0]     op_r;
   logic signed [2*W+1:0] product;

   assign gcd_done = (u_ff == '0) || (v_ff == '0);
   assign trial1   = {rem1_ff, q1_ff[DW-1]} - {1'b0, g_ff};
   assign trial2   = {rem2_ff, q2_ff[DW-1]} - {1'b0, g_ff};
   assign product  = op_l * op_r;

   always_comb begin
      op_l = '0;
      op_r = '0;
      case (mul_ff)
         fau_pkg::MUL_LCM: begin
            op_l = {2'b00, q1_ff};
            op_r = {2'b00, b_ff};
         end
         fau_pkg::MUL_T1: begin
            op_l = {x_ff[W-1], x_ff};
            op_r = {2'b00, q2_ff};
         end
         fau_pkg::MUL_T2: begin
            op_l = {a_ff[W-1], a_ff};
            op_r = {2'b00, q1_ff};
         end
         fau_pkg::MUL_PN: begin
            op_l = {x_ff[W-1], x_ff};
            op_r = {a_ff[W-1], a_ff};
         end
         fau_pkg::MUL_PD: begin
            op_l = {2'b00, y_ff};
            op_r = {2'b00, b_ff};
         end
         fau_pkg::MUL_QN: begin
            op_l = {x_ff[W-1], x_ff};
            op_r = {2'b00, b_ff};
         end
         fau_pkg::MUL_QD: begin
            op_l = {2'b00, y_ff};
            op_r = {a_ff[W-1], a_ff};
         end
         default: begin
            op_l = '0;
            op_r = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      q_ready   = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         fau_pkg::BK_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               state_in = fau_pkg::BK_GCD;
            end
         end
         fau_pkg::BK_GCD: begin
            if (gcd_done) begin
               state_in = fau_pkg::BK_DIV;
            end
         end
         fau_pkg::BK_DIV: begin
            if (g_ff == '0 || dcnt_ff == KW'(DW - 1)) begin
               state_in = fau_pkg::BK_MUL;
            end
         end
         fau_pkg::BK_MUL: begin
            if (mul_ff == fau_pkg::MUL_QD) begin
               state_in = fau_pkg::BK_SUM;
            end
         end
         fau_pkg::BK_SUM: begin
            state_in = fau_pkg::BK_OUT;
         end
         fau_pkg::BK_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = fau_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = fau_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fau_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         fau_pkg::BK_IDLE: begin
            x_ff  <= q_x;
            a_ff  <= q_a;
            y_ff  <= q_y;
            b_ff  <= q_b;
            yz_ff <= q_y_zero;
            bz_ff <= q_b_zero;
            u_ff  <= q_y;
            v_ff  <= q_b;
            k_ff  <= '0;
         end
         fau_pkg::BK_GCD: begin
            // binary gcd, one step per cycle
            if (gcd_done) begin
               g_ff    <= (u_ff | v_ff) << k_ff;
               rem1_ff <= '0;
               rem2_ff <= '0;
               q1_ff   <= y_ff;
               q2_ff   <= b_ff;
               dcnt_ff <= '0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_ff <= u_ff - v_ff;
            end else begin
               v_ff <= v_ff - u_ff;
            end
         end
         fau_pkg::BK_DIV: begin
            // two restoring dividers by the gcd in lockstep
            mul_ff <= fau_pkg::MUL_LCM;
            if (g_ff == '0) begin
               q1_ff <= '0;
               q2_ff <= '0;
            end else begin
               dcnt_ff <= dcnt_ff + KW'(1);
               if (!trial1[DW]) begin
                  rem1_ff <= trial1[DW-1:0];
                  q1_ff   <= {q1_ff[DW-2:0], 1'b1};
               end else begin
                  rem1_ff <= {rem1_ff[DW-2:0], q1_ff[DW-1]};
                  q1_ff   <= {q1_ff[DW-2:0], 1'b0};
               end
               if (!trial2[DW]) begin
                  rem2_ff <= trial2[DW-1:0];
                  q2_ff   <= {q2_ff[DW-2:0], 1'b1};
               end else begin
                  rem2_ff <= {rem2_ff[DW-2:0], q2_ff[DW-1]};
                  q2_ff   <= {q2_ff[DW-2:0], 1'b0};
               end
            end
         end
         fau_pkg::BK_MUL: begin
            mul_ff <= fau_pkg::mul_sel_type'(mul_ff + 3'd1);
            case (mul_ff)
               fau_pkg::MUL_LCM: lcm_ff <= product[2*W-3:0];
               fau_pkg::MUL_T1:  t1_ff  <= yz_ff ? '0 : product[2*W-1:0];
               fau_pkg::MUL_T2:  t2_ff  <= bz_ff ? '0 : product[2*W-1:0];
               fau_pkg::MUL_PN:  pn_ff  <= product[2*W-1:0];
               fau_pkg::MUL_PD:  pd_ff  <= product[2*W-3:0];
               fau_pkg::MUL_QN:  qn_ff  <= product[2*W-2:0];
               fau_pkg::MUL_QD:  qd_ff  <= product[2*W-2:0];
               default:          pn_ff  <= pn_ff;
            endcase
         end
         fau_pkg::BK_SUM: begin
            sum_ff  <= t1_ff + t2_ff;
            diff_ff <= t1_ff - t2_ff;
         end
         default: begin
            sum_ff <= sum_ff;
         end
      endcase
   end

   assign den_gcd    = g_ff;
   assign common_den = lcm_ff;
   assign sum_num    = sum_ff;
   assign diff_num   = diff_ff;
   assign prod_num   = pn_ff;
   assign prod_den   = pd_ff;
   assign quot_num   = qn_ff;
   assign quot_den   = qd_ff;

endmodule

>>> rtl/fraction_arithmetic_unit.sv
// flow: the back end runs the binary gcd loop, one step per cycle, then the two dividers
// by the gcd, the multiplies and the sum and difference, and holds the result until taken
// throughput: one transaction at a time in the back end, so the next result starts only
// after the previous one is taken; a two-entry queue keeps taking input transactions meanwhile
// reset: synchronous, active high; clears the queue and returns the back end to idle
`timescale 1ns / 1ps

module fraction_arithmetic_unit #(
   parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // num_first, den_first, num_second, den_second, zero pad
   input  logic [(((4*OPERAND_WIDTH-2)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // den_gcd, common_den, sum_num, diff_num, prod_num, prod_den, quot_num, quot_den, zero pad
   output logic [(((15*OPERAND_WIDTH-7)+7)/8)*8-1:0] rsp_tdata
);

   localparam int W       = OPERAND_WIDTH;
   localparam int OUT_BITS = 15 * W - 7;
   localparam int OUT_PAD  = (((OUT_BITS + 7) / 8) * 8) - OUT_BITS;

   logic                  q_valid;
   logic                  q_ready;
   logic signed [W-1:0]   q_x;
   logic        [W-2:0]   q_y;
   logic signed [W-1:0]   q_a;
   logic        [W-2:0]   q_b;
   logic                  q_y_zero;
   logic                  q_b_zero;
   logic        [W-2:0]   den_gcd;
   logic        [2*W-3:0] common_den;
   logic signed [2*W-1:0] sum_num;
   logic signed [2*W-1:0] diff_num;
   logic signed [2*W-1:0] prod_num;
   logic        [2*W-3:0] prod_den;
   logic signed [2*W-2:0] quot_num;
   logic signed [2*W-2:0] quot_den;

   fau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_x       (req_tdata[W-1:0]),
      .in_y       (req_tdata[2*W-2:W]),
      .in_a       (req_tdata[3*W-2:2*W-1]),
      .in_b       (req_tdata[4*W-3:3*W-1]),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_x        (q_x),
      .q_y        (q_y),
      .q_a        (q_a),
      .q_b        (q_b),
      .q_y_zero   (q_y_zero),
      .q_b_zero   (q_b_zero)
   );

   fau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_x        (q_x),
      .q_y        (q_y),
      .q_a        (q_a),
      .q_b        (q_b),
      .q_y_zero   (q_y_zero),
      .q_b_zero   (q_b_zero),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .den_gcd    (den_gcd),
      .common_den (common_den),
      .sum_num    (sum_num),
      .diff_num   (diff_num),
      .prod_num   (prod_num),
      .prod_den   (prod_den),
      .quot_num   (quot_num),
      .quot_den   (quot_den)
   );

   assign rsp_tdata = {{OUT_PAD{1'b0}}, quot_den, quot_num, prod_den, prod_num,
                       diff_num, sum_num, common_den, den_gcd};

endmodule

>>> rtl/fau_checker.sv
`timescale 1ns / 1ps

module fau_checker #(
   parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [(((15*OPERAND_WIDTH-7)+7)/8)*8-1:0] rsp_tdata
);

   localparam int OUT_BITS = 15 * OPERAND_WIDTH - 7;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> OUT_BITS) == OUT_W'(0))
      else $error("pad bits of result not zero");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("queue not ready after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid)
      else $error("input transaction withdrawn before it was taken");

endmodule

bind fraction_arithmetic_unit fau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_fau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/fraction_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module fraction_arithmetic_unit_tb;

   localparam int W = fau_pkg::OPERAND_WIDTH_DEFAULT;
   localparam int REQ_W = (((4*W-2)+7)/8)*8;
   localparam int RSP_W = (((15*W-7)+7)/8)*8;
   localparam int RES_BITS = 233;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   fraction_arithmetic_unit #(.OPERAND_WIDTH(W)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   class fraction_scoreboard;
      logic [RES_BITS-1:0] pending[$];
      int errors;
      int checked;
      int zero_dens;

      function new();
         errors = 0;
         checked = 0;
         zero_dens = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      function logic [RES_BITS-1:0] fraction_results(input logic [REQ_W-1:0] d);
         longint x, a, t1, t2, sum, diff, pn, qn, qd;
         longint unsigned y, b, g, q, r, l, pd;
         x = longint'(signed'(d[15:0]));
         y = longint'(d[30:16]);
         a = longint'(signed'(d[46:31]));
         b = longint'(d[61:47]);
         g = y;
         q = b;
         while (q != 0) begin
            r = g % q;
            g = q;
            q = r;
         end
         l = (g != 0) ? (y / g) * b : 0;
         t1 = (y != 0) ? x * longint'(l / y) : 0;
         t2 = (b != 0) ? a * longint'(l / b) : 0;
         sum = t1 + t2;
         diff = t1 - t2;
         pn = x * a;
         pd = y * b;
         qn = x * longint'(b);
         qd = longint'(y) * a;
         return {qd[30:0], qn[30:0], pd[29:0], pn[31:0], diff[31:0], sum[31:0],
                 l[29:0], g[14:0]};
      endfunction

      function void note(input logic [REQ_W-1:0] d);
         if (d[30:16] == 0 || d[61:47] == 0) zero_dens++;
         pending.push_back(fraction_results(d));
      endfunction

      task check(input logic [RSP_W-1:0] v);
         logic [RES_BITS-1:0] exp_v;
         logic [RES_BITS-1:0] got_v;
         logic [RES_BITS-1:0] mask;
         int lo[8];
         int wd[8];
         string nm[8];
         lo = '{0, 15, 45, 77, 109, 141, 171, 202};
         wd = '{15, 30, 32, 32, 32, 30, 31, 31};
         nm = '{"den_gcd", "common_den", "sum_num", "diff_num", "prod_num", "prod_den",
                "quot_num", "quot_den"};
         checked++;
         if (pending.size() == 0) begin
            report("result transaction with nothing expected");
         end else begin
            exp_v = pending.pop_front();
            got_v = v[RES_BITS-1:0];
            for (int i = 0; i < 8; i++) begin
               mask = (({{(RES_BITS-1){1'b0}}, 1'b1}) << wd[i]) - 1;
               if (((got_v >> lo[i]) & mask) != ((exp_v >> lo[i]) & mask))
                  report($sformatf("%s got %h expected %h", nm[i],
                                   (got_v >> lo[i]) & mask, (exp_v >> lo[i]) & mask));
            end
         end
      endtask
   endclass

   fraction_scoreboard sb;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("fraction_arithmetic_unit_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
   end

   // receiver stall pattern: modes of random length
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 200);
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= (stall_left % 3 != 0);
         endcase
      end
   end

   function logic [REQ_W-1:0] pack_fractions(input logic [15:0] x, input logic [14:0] y,
                                             input logic [15:0] a, input logic [14:0] b);
      pack_fractions = '0;
      pack_fractions[61:0] = {b, a, y, x};
   endfunction

   task drive_transaction(input logic [REQ_W-1:0] d);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task idle_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function logic [14:0] random_den();
      int k;
      k = $urandom_range(0, 99);
      if (k < 3) return 15'd0;
      if (k < 30) return 15'($urandom_range(1, 64));
      if (k < 40) return 15'(32768 - $urandom_range(1, 8));
      return 15'($urandom_range(1, 32767));
   endfunction

   function logic [15:0] random_num();
      int k;
      k = $urandom_range(0, 99);
      if (k < 5) return 16'h8000;
      if (k < 10) return 16'h7fff;
      if (k < 15) return 16'($urandom_range(0, 2) - 1);
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] nums[6];
      logic [14:0] dens[5];
      int burst;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      nums = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h1234};
      dens = '{15'd0, 15'd1, 15'h7fff, 15'd12, 15'd18};
      // extremes, zero denominators and shared factors, then a grid of corner values
      drive_transaction(pack_fractions(16'h8000, 15'h7fff, 16'h8000, 15'h7fff));
      drive_transaction(pack_fractions(16'h7fff, 15'h7fff, 16'h7fff, 15'h7ffe));
      drive_transaction(pack_fractions(16'h8000, 15'h7fff, 16'h7fff, 15'h7ffe));
      drive_transaction(pack_fractions(16'h7fff, 15'd1, 16'h8000, 15'd1));
      drive_transaction(pack_fractions(16'h0005, 15'd0, 16'h0003, 15'd0));
      drive_transaction(pack_fractions(16'hfffb, 15'd7, 16'h0003, 15'd0));
      drive_transaction(pack_fractions(16'h0005, 15'd0, 16'h8000, 15'd9));
      drive_transaction(pack_fractions(16'h0000, 15'd12, 16'h0000, 15'd18));
      drive_transaction(pack_fractions(16'h0001, 15'd12, 16'hffff, 15'd18));
      drive_transaction(pack_fractions(16'h0001, 15'h4000, 16'h0001, 15'h2000));
      drive_transaction(pack_fractions(16'h0003, 15'd5, 16'h0003, 15'd5));
      for (int i = 0; i < 12; i++)
         drive_transaction(pack_fractions(nums[i % 6], dens[i % 5], nums[(i + 3) % 6],
                                          dens[(i + 2) % 5]));
      drain();

      burst = 0;
      for (int i = 0; i < 1200; i++) begin
         if (burst == 0) begin
            idle_sender($urandom_range(0, 3) == 0 ? $urandom_range(1, 80) :
                        $urandom_range(1, 4));
            burst = $urandom_range(1, 30);
         end
         if (i == 600) drain();
         drive_transaction(pack_fractions(random_num(), random_den(), random_num(),
                                          random_den()));
         burst--;
      end
      drain();
      repeat (100) @(posedge clock);

      $display("covered %0d results, %0d with a zero denominator, extremes and stalls",
               sb.checked, sb.zero_dens);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("fraction_arithmetic_unit_tb: clean");
      end else begin
         $display("fraction_arithmetic_unit_tb: errors");
      end
      $finish;
   end

endmodule
